// File: rtl/ncc_pkg.sv
// shared constants, codes and control types of the nearest centroid classifier
package ncc_pkg;

    localparam int MAX_REFS      = 64;
    localparam int MAX_LENGTH    = 64;
    localparam int ELEMENT_BITS  = 16;
    localparam int LABEL_BITS    = 8;
    localparam int SLOT_BITS     = $clog2(MAX_REFS);
    localparam int IDX_BITS      = $clog2(MAX_LENGTH);
    localparam int REF_ADDR_BITS = SLOT_BITS + IDX_BITS;
    localparam int CFG_BITS      = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int SUM_BITS      = 40;
    localparam int MAG_BITS      = ELEMENT_BITS + 1;
    localparam int SQ_BITS       = 2 * MAG_BITS;
    localparam int LIMIT_BITS    = 20;

    localparam logic [SUM_BITS-1:0]   SUM_MAX        = {SUM_BITS{1'b1}};
    localparam logic [LIMIT_BITS-1:0] DIFF_SAT_LIMIT = {LIMIT_BITS{1'b1}};

    localparam logic [CFG_BITS-1:0] MAX_REFS_C   = CFG_BITS'(MAX_REFS);
    localparam logic [CFG_BITS-1:0] MAX_LENGTH_C = CFG_BITS'(MAX_LENGTH);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_VECTOR_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REFERENCE_COUNT = 2'd1;

    typedef enum logic [1:0] {
        CMD_REF_WRITE   = 2'd0,
        CMD_LABEL_WRITE = 2'd1,
        CMD_SAMPLE      = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_LABEL,
        ST_DONE
    } t_state;

    // sequencer to distance engine, store and output register
    typedef struct packed {
        logic                           issue;
        logic [SLOT_BITS-1:0]           slot;
        logic [IDX_BITS-1:0]            idx;
        logic                           upd;
        logic                           start;
        logic                           clear;
        logic signed [ELEMENT_BITS-1:0] value;
        logic                           load;
        logic                           nores;
    } t_seq_ctl;

    // distance engine status back to the sequencer
    typedef struct packed {
        logic                 busy;
        logic [SLOT_BITS-1:0] best_slot;
        logic [SUM_BITS-1:0]  best_sum;
    } t_dist_stat;

endpackage

// File: rtl/ncc_store.sv
// reference element memory and label memory
module ncc_store (
    input  logic                                   i_clk,
    input  logic                                   i_ref_we,
    input  logic [ncc_pkg::REF_ADDR_BITS-1:0]      i_ref_waddr,
    input  logic signed [ncc_pkg::ELEMENT_BITS-1:0] i_ref_wdata,
    input  logic [ncc_pkg::REF_ADDR_BITS-1:0]      i_ref_raddr,
    output logic signed [ncc_pkg::ELEMENT_BITS-1:0] o_ref_rdata,
    input  logic                                   i_lab_we,
    input  logic [ncc_pkg::SLOT_BITS-1:0]          i_lab_waddr,
    input  logic [ncc_pkg::LABEL_BITS-1:0]         i_lab_wdata,
    input  logic [ncc_pkg::SLOT_BITS-1:0]          i_lab_raddr,
    output logic [ncc_pkg::LABEL_BITS-1:0]         o_lab_rdata
);

    logic signed [ncc_pkg::ELEMENT_BITS-1:0] r_ref_mem [ncc_pkg::MAX_REFS * ncc_pkg::MAX_LENGTH];
    logic [ncc_pkg::LABEL_BITS-1:0]          r_lab_mem [ncc_pkg::MAX_REFS];

    always_ff @(posedge i_clk) begin
        if (i_ref_we) begin
            r_ref_mem[i_ref_waddr] <= i_ref_wdata;
        end
        o_ref_rdata <= r_ref_mem[i_ref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_lab_we) begin
            r_lab_mem[i_lab_waddr] <= i_lab_wdata;
        end
        o_lab_rdata <= r_lab_mem[i_lab_raddr];
    end

endmodule

// File: rtl/ncc_dist.sv
// distance sum memory, square-accumulate pipeline and running minimum
module ncc_dist (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ncc_pkg::t_seq_ctl                       i_ctl,
    input  logic signed [ncc_pkg::ELEMENT_BITS-1:0] i_ref_rdata,
    output ncc_pkg::t_dist_stat                     o_stat
);

    logic [ncc_pkg::SUM_BITS-1:0] r_sum_mem [ncc_pkg::MAX_REFS];
    logic [ncc_pkg::MAX_REFS-1:0] r_sum_ok;

    // stage 1: memory read data
    logic                          r_p1_vld;
    logic [ncc_pkg::SLOT_BITS-1:0] r_p1_slot;
    logic                          r_p1_upd;
    logic [ncc_pkg::SUM_BITS-1:0]  r_p1_sum;
    logic                          r_p1_ok;

    // stage 2: squared difference
    logic                          r_p2_vld;
    logic [ncc_pkg::SLOT_BITS-1:0] r_p2_slot;
    logic                          r_p2_upd;
    logic [ncc_pkg::SUM_BITS-1:0]  r_p2_old;
    logic [ncc_pkg::SQ_BITS-1:0]   r_p2_sq;
    logic                          r_p2_big;

    // stage 3: new sum
    logic                          r_p3_vld;
    logic [ncc_pkg::SLOT_BITS-1:0] r_p3_slot;
    logic [ncc_pkg::SUM_BITS-1:0]  r_p3_sum;

    logic                          r_best_vld;
    logic [ncc_pkg::SLOT_BITS-1:0] r_best_slot;
    logic [ncc_pkg::SUM_BITS-1:0]  r_best_sum;

    logic signed [ncc_pkg::MAG_BITS-1:0] diff;
    logic [ncc_pkg::MAG_BITS-1:0]        mag;
    logic [ncc_pkg::SUM_BITS:0]          wide_sum;
    logic [ncc_pkg::SUM_BITS-1:0]        new_sum;

    always_comb begin
        diff = ncc_pkg::MAG_BITS'(i_ctl.value) - ncc_pkg::MAG_BITS'(i_ref_rdata);
        mag  = diff[ncc_pkg::MAG_BITS-1] ? ncc_pkg::MAG_BITS'(-diff) : ncc_pkg::MAG_BITS'(diff);
    end

    always_comb begin
        wide_sum = {1'b0, r_p2_old}
                 + {{(ncc_pkg::SUM_BITS + 1 - ncc_pkg::SQ_BITS){1'b0}}, r_p2_sq};
        if (!r_p2_upd) begin
            new_sum = r_p2_old;
        end else if (r_p2_big || wide_sum[ncc_pkg::SUM_BITS]) begin
            new_sum = ncc_pkg::SUM_MAX;
        end else begin
            new_sum = wide_sum[ncc_pkg::SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_sum  <= r_sum_mem[i_ctl.slot];
        r_p1_ok   <= r_sum_ok[i_ctl.slot];
        r_p1_slot <= i_ctl.slot;
        r_p1_upd  <= i_ctl.upd;

        r_p2_slot <= r_p1_slot;
        r_p2_upd  <= r_p1_upd;
        r_p2_old  <= r_p1_ok ? r_p1_sum : '0;
        r_p2_sq   <= mag * mag;
        r_p2_big  <= {{(ncc_pkg::LIMIT_BITS - ncc_pkg::MAG_BITS){1'b0}}, mag}
                     > ncc_pkg::DIFF_SAT_LIMIT;

        r_p3_slot <= r_p2_slot;
        r_p3_sum  <= new_sum;
        if (r_p2_vld) begin
            r_sum_mem[r_p2_slot] <= new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_p3_vld   <= 1'b0;
            r_sum_ok   <= '0;
            r_best_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_ctl.issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            if (i_ctl.clear) begin
                r_sum_ok <= '0;
            end else if (r_p2_vld) begin
                r_sum_ok[r_p2_slot] <= 1'b1;
            end
            // strict compare keeps the lowest slot on ties
            if (i_ctl.start) begin
                r_best_vld <= 1'b0;
            end else if (r_p3_vld && (!r_best_vld || r_p3_sum < r_best_sum)) begin
                r_best_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.start && r_p3_vld && (!r_best_vld || r_p3_sum < r_best_sum)) begin
            r_best_slot <= r_p3_slot;
            r_best_sum  <= r_p3_sum;
        end
    end

    assign o_stat.busy      = r_p1_vld || r_p2_vld || r_p3_vld;
    assign o_stat.best_slot = r_best_slot;
    assign o_stat.best_sum  = r_best_sum;

endmodule

// File: rtl/ncc_seq.sv
// sequencer: walks the references for each sample element and ends the sample
module ncc_seq (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  ncc_pkg::t_cmd                           i_cmd,
    input  logic [ncc_pkg::IDX_BITS-1:0]            i_idx,
    input  logic signed [ncc_pkg::ELEMENT_BITS-1:0] i_value,
    input  logic                                    i_last,
    input  logic [ncc_pkg::CFG_BITS-1:0]            i_len,
    input  logic [ncc_pkg::CFG_BITS-1:0]            i_cnt,
    input  logic                                    i_out_free,
    input  ncc_pkg::t_dist_stat                     i_stat,
    output logic                                    o_ready,
    output ncc_pkg::t_seq_ctl                       o_ctl
);

    ncc_pkg::t_state r_state, n_state;
    logic [ncc_pkg::SLOT_BITS-1:0]           r_ptr,   n_ptr;
    logic [ncc_pkg::IDX_BITS-1:0]            r_idx,   n_idx;
    logic signed [ncc_pkg::ELEMENT_BITS-1:0] r_value, n_value;
    logic                                    r_upd,   n_upd;
    logic                                    r_last,  n_last;
    logic                                    r_nores, n_nores;
    logic                                    in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncc_pkg::ST_IDLE;
            r_ptr   <= '0;
            r_upd   <= 1'b0;
            r_last  <= 1'b0;
            r_nores <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_upd   <= n_upd;
            r_last  <= n_last;
            r_nores <= n_nores;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_value <= n_value;
    end

    assign in_range = {1'b0, i_idx} < i_len;

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_idx   = r_idx;
        n_value = r_value;
        n_upd   = r_upd;
        n_last  = r_last;
        n_nores = r_nores;
        o_ready = 1'b0;
        o_ctl   = '0;
        o_ctl.slot  = r_ptr;
        o_ctl.idx   = r_idx;
        o_ctl.upd   = r_upd;
        o_ctl.value = r_value;
        o_ctl.nores = r_nores;

        unique case (r_state)
            ncc_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && i_cmd == ncc_pkg::CMD_SAMPLE) begin
                    n_idx   = i_idx;
                    n_value = i_value;
                    n_upd   = in_range;
                    n_last  = i_last;
                    n_ptr   = '0;
                    if (i_cnt == '0) begin
                        n_nores = 1'b1;
                        if (i_last) begin
                            n_state = ncc_pkg::ST_DONE;
                        end
                    end else if (in_range || i_last) begin
                        n_nores     = 1'b0;
                        o_ctl.start = 1'b1;
                        n_state     = ncc_pkg::ST_SCAN;
                    end
                end
            end
            ncc_pkg::ST_SCAN: begin
                o_ctl.issue = 1'b1;
                n_ptr = r_ptr + 1'b1;
                if ({1'b0, r_ptr} == i_cnt - 1'b1) begin
                    n_state = ncc_pkg::ST_DRAIN;
                end
            end
            ncc_pkg::ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = r_last ? ncc_pkg::ST_LABEL : ncc_pkg::ST_IDLE;
                end
            end
            ncc_pkg::ST_LABEL: begin
                // label read of the winner lands here
                n_state = ncc_pkg::ST_DONE;
            end
            ncc_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_ctl.load  = 1'b1;
                    o_ctl.clear = 1'b1;
                    n_state     = ncc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ncc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/nearest_centroid_classifier.sv
// nearest centroid classifier top level: ports, configuration and result register
// a write command is taken and written on its beat; an in-range sample element scans the
//   cnt references in use, one reference per cycle, then drains the distance pipeline
// the last element of a sample then reads the winner's label and waits for a free result register
// no new beat is taken while an element is in the scan or the drain
// reset: config to length 1 and count 0, all sums read as zero, result register empty;
//   reference and label memories hold nothing defined until written, with no clearing pass
module nearest_centroid_classifier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample and write commands
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [39:0]                        i_s_axis_tdata,  // ref_slot, element_index, element_value, label_value
    input  logic [1:0]                         i_s_axis_tuser,  // cmd
    input  logic                               i_s_axis_tlast,  // sample_end
    // classification results
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [55:0]                        o_m_axis_tdata,  // winner_label, winner_slot, winner_distance
    output logic [0:0]                         o_m_axis_tuser,  // no_references
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ncc_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ncc_pkg::CFG_BITS-1:0]       i_cfg_data
);

    // unpacked input beat
    logic [ncc_pkg::SLOT_BITS-1:0]           in_slot;
    logic [ncc_pkg::IDX_BITS-1:0]            in_idx;
    logic signed [ncc_pkg::ELEMENT_BITS-1:0] in_value;
    logic [ncc_pkg::LABEL_BITS-1:0]          in_label;
    ncc_pkg::t_cmd                           in_cmd;
    logic                                    in_acc;

    logic [ncc_pkg::CFG_BITS-1:0] r_vector_length;
    logic [ncc_pkg::CFG_BITS-1:0] r_reference_count;
    logic [ncc_pkg::CFG_BITS-1:0] len_use;
    logic [ncc_pkg::CFG_BITS-1:0] cnt_use;

    ncc_pkg::t_seq_ctl   ctl;
    ncc_pkg::t_dist_stat stat;
    logic                                    seq_ready;
    logic signed [ncc_pkg::ELEMENT_BITS-1:0] ref_rdata;
    logic [ncc_pkg::LABEL_BITS-1:0]          lab_rdata;

    // result register
    logic                           r_out_vld;
    logic [ncc_pkg::LABEL_BITS-1:0] r_out_label;
    logic [ncc_pkg::SLOT_BITS-1:0]  r_out_slot;
    logic [ncc_pkg::SUM_BITS-1:0]   r_out_dist;
    logic                           r_out_nores;
    logic                           out_free;

    assign in_slot  = i_s_axis_tdata[5:0];
    assign in_idx   = i_s_axis_tdata[11:6];
    assign in_value = i_s_axis_tdata[27:12];
    assign in_label = i_s_axis_tdata[35:28];
    assign in_cmd   = ncc_pkg::t_cmd'(i_s_axis_tuser);

    assign o_s_axis_tready = seq_ready;
    assign in_acc          = i_s_axis_tvalid && seq_ready;

    // registers above the store size act as the store size
    assign len_use = (r_vector_length > ncc_pkg::MAX_LENGTH_C)
                   ? ncc_pkg::MAX_LENGTH_C : r_vector_length;
    assign cnt_use = (r_reference_count > ncc_pkg::MAX_REFS_C)
                   ? ncc_pkg::MAX_REFS_C : r_reference_count;

    // configuration is always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_length   <= ncc_pkg::CFG_BITS'(1);
            r_reference_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ncc_pkg::CFG_VECTOR_LENGTH:   r_vector_length   <= i_cfg_data;
                ncc_pkg::CFG_REFERENCE_COUNT: r_reference_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ncc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_cmd      (in_cmd),
        .i_idx      (in_idx),
        .i_value    (in_value),
        .i_last     (i_s_axis_tlast),
        .i_len      (len_use),
        .i_cnt      (cnt_use),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_ready    (seq_ready),
        .o_ctl      (ctl)
    );

    // write commands go straight into the memories on their beat
    ncc_store u_store (
        .i_clk       (i_clk),
        .i_ref_we    (in_acc && in_cmd == ncc_pkg::CMD_REF_WRITE),
        .i_ref_waddr ({in_slot, in_idx}),
        .i_ref_wdata (in_value),
        .i_ref_raddr ({ctl.slot, ctl.idx}),
        .o_ref_rdata (ref_rdata),
        .i_lab_we    (in_acc && in_cmd == ncc_pkg::CMD_LABEL_WRITE),
        .i_lab_waddr (in_slot),
        .i_lab_wdata (in_label),
        .i_lab_raddr (stat.best_slot),
        .o_lab_rdata (lab_rdata)
    );

    ncc_dist u_dist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_ref_rdata (ref_rdata),
        .o_stat      (stat)
    );

    // result register decouples the sequencer from the output stall
    assign out_free = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctl.load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    // with no references every field reads zero and the flag is set
    always_ff @(posedge i_clk) begin
        if (ctl.load) begin
            r_out_nores <= ctl.nores;
            r_out_label <= ctl.nores ? '0 : lab_rdata;
            r_out_slot  <= ctl.nores ? '0 : stat.best_slot;
            r_out_dist  <= ctl.nores ? '0 : stat.best_sum;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {2'b00, r_out_dist, r_out_slot, r_out_label};
    assign o_m_axis_tuser  = r_out_nores;

    // no new beat is taken while sums are still in flight
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> !o_s_axis_tready)
        else $error("input taken while distance pipeline busy");

    // an empty reference set reports all zero fields
    a_nores_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("no-reference result carries nonzero fields");

    // the winner is one of the references in use
    a_slot_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> ({1'b0, o_m_axis_tdata[13:8]} < cnt_use))
        else $error("winner slot beyond reference count");

    // a result is loaded only after the pipeline has emptied
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |-> (!stat.busy && out_free))
        else $error("result loaded with sums in flight or output full");

endmodule

// File: tb/tb_nearest_centroid_classifier.sv
// self-checking testbench of the nearest centroid classifier with a built-in distance predictor
module tb_nearest_centroid_classifier;

    // the one code the block ignores
    localparam logic [1:0] CMD_RESERVED  = 2'd3;
    // covers the longest element still in flight once the last result is out
    localparam int         SETTLE_CYCLES = 80;
    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         RANDOM_BEATS  = 1300;

    typedef struct {
        logic [1:0]                              cmd;
        logic [ncc_pkg::SLOT_BITS-1:0]           slot;
        logic [ncc_pkg::IDX_BITS-1:0]            idx;
        logic signed [ncc_pkg::ELEMENT_BITS-1:0] value;
        logic [ncc_pkg::LABEL_BITS-1:0]          label;
        logic                                    last;
    } t_cmd_beat;

    typedef struct {
        logic [ncc_pkg::LABEL_BITS-1:0] label;
        logic [ncc_pkg::SLOT_BITS-1:0]  slot;
        logic [ncc_pkg::SUM_BITS-1:0]   distance;
        logic                           nores;
    } t_winner;

    logic                             i_clk;
    logic                             i_rst_n          = 1'b0;
    logic                             i_s_axis_tvalid  = 1'b0;
    logic                             o_s_axis_tready;
    logic [39:0]                      i_s_axis_tdata   = '0;
    logic [1:0]                       i_s_axis_tuser   = '0;
    logic                             i_s_axis_tlast   = 1'b0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready  = 1'b0;
    logic [55:0]                      o_m_axis_tdata;
    logic [0:0]                       o_m_axis_tuser;
    logic                             i_cfg_valid      = 1'b0;
    logic                             o_cfg_ready;
    logic [ncc_pkg::CFG_IDX_BITS-1:0] i_cfg_index      = '0;
    logic [ncc_pkg::CFG_BITS-1:0]     i_cfg_data       = '0;

    nearest_centroid_classifier u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // predictor copy of the block state
    logic signed [ncc_pkg::ELEMENT_BITS-1:0] ref_vec   [ncc_pkg::MAX_REFS][ncc_pkg::MAX_LENGTH];
    logic [ncc_pkg::LABEL_BITS-1:0]          ref_label [ncc_pkg::MAX_REFS];
    logic [ncc_pkg::SUM_BITS-1:0]            dist_sum  [ncc_pkg::MAX_REFS] = '{default: '0};
    logic [ncc_pkg::CFG_BITS-1:0]            cfg_len   = ncc_pkg::CFG_BITS'(1);
    logic [ncc_pkg::CFG_BITS-1:0]            cfg_count = '0;

    // stimulus side bookkeeping: entries already queued for writing
    bit        ref_known   [ncc_pkg::MAX_REFS][ncc_pkg::MAX_LENGTH];
    bit        label_known [ncc_pkg::MAX_REFS];

    t_cmd_beat command_beats[$];
    t_winner   pending_winners[$];
    t_cmd_beat beat_on_bus;
    // monitor flips taken_mark per accepted beat, driver follows with seen_mark
    bit        taken_mark   = 1'b0;
    bit        seen_mark    = 1'b0;
    bit        no_gaps      = 1'b0;
    bit        counting     = 1'b0;
    int        random_beats = 0;
    int        errors       = 0;
    int        cycles       = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h", what, got, want);
        errors++;
    endtask

    // one squared difference into a 40-bit sum, sticking at the top
    function automatic logic [ncc_pkg::SUM_BITS-1:0] add_square(
            input logic [ncc_pkg::SUM_BITS-1:0] sum,
            input logic signed [ncc_pkg::ELEMENT_BITS-1:0] a,
            input logic signed [ncc_pkg::ELEMENT_BITS-1:0] b);
        logic signed [ncc_pkg::ELEMENT_BITS:0] d;
        logic [ncc_pkg::ELEMENT_BITS:0]        mag;
        logic [ncc_pkg::SUM_BITS:0]            t;
        d   = $signed({a[ncc_pkg::ELEMENT_BITS-1], a}) - $signed({b[ncc_pkg::ELEMENT_BITS-1], b});
        mag = d[ncc_pkg::ELEMENT_BITS] ? -d : d;
        t   = {1'b0, sum} + (ncc_pkg::SUM_BITS+1)'(mag) * (ncc_pkg::SUM_BITS+1)'(mag);
        return t[ncc_pkg::SUM_BITS] ? ncc_pkg::SUM_MAX : t[ncc_pkg::SUM_BITS-1:0];
    endfunction

    // applies one accepted beat to the predictor state, queueing a winner on sample end
    task automatic classify_beat(input t_cmd_beat b);
        int unsigned len_use;
        int unsigned cnt_use;
        int          best;
        t_winner     w;
        len_use = (cfg_len > ncc_pkg::MAX_LENGTH) ? ncc_pkg::MAX_LENGTH : cfg_len;
        cnt_use = (cfg_count > ncc_pkg::MAX_REFS) ? ncc_pkg::MAX_REFS : cfg_count;
        case (b.cmd)
            ncc_pkg::CMD_REF_WRITE:   ref_vec[b.slot][b.idx] = b.value;
            ncc_pkg::CMD_LABEL_WRITE: ref_label[b.slot] = b.label;
            ncc_pkg::CMD_SAMPLE: begin
                if (b.idx < len_use)
                    for (int r = 0; r < cnt_use; r++)
                        dist_sum[r] = add_square(dist_sum[r], b.value, ref_vec[r][b.idx]);
                if (b.last) begin
                    if (cnt_use == 0) begin
                        w = '{label: '0, slot: '0, distance: '0, nores: 1'b1};
                    end else begin
                        // strict compare keeps the lowest index on ties
                        best = 0;
                        for (int r = 1; r < cnt_use; r++)
                            if (dist_sum[r] < dist_sum[best])
                                best = r;
                        w = '{label: ref_label[best], slot: ncc_pkg::SLOT_BITS'(best),
                              distance: dist_sum[best], nores: 1'b0};
                    end
                    pending_winners.push_back(w);
                    dist_sum = '{default: '0};
                end
            end
            default: ;
        endcase
    endtask

    // command driver: a held beat stays put until taken, then the next one or a gap
    always @(negedge i_clk) begin : drive_commands
        t_cmd_beat nxt;
        bit        gap;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || taken_mark != seen_mark) begin
            seen_mark = taken_mark;
            gap = !no_gaps && ($urandom_range(99) < 35);
            if (command_beats.size() != 0 && !gap) begin
                nxt             = command_beats.pop_front();
                beat_on_bus     = nxt;
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {4'b0, nxt.label, nxt.value, nxt.idx, nxt.slot};
                i_s_axis_tuser  <= nxt.cmd;
                i_s_axis_tlast  <= nxt.last;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        i_m_axis_tready <= no_gaps || ($urandom_range(99) >= 35);
    end

    // monitor: results against the oldest expected winner, accepted beats into the predictor
    always @(posedge i_clk) begin : watch_beats
        t_winner want;
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end else if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_winners.size() == 0) begin
                    report_mismatch("result with none expected", 64'(o_m_axis_tdata), '0);
                end else begin
                    want = pending_winners.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.label)
                        report_mismatch("winner_label", 64'(o_m_axis_tdata[7:0]),
                                        64'(want.label));
                    if (o_m_axis_tdata[13:8] !== want.slot)
                        report_mismatch("winner_slot", 64'(o_m_axis_tdata[13:8]),
                                        64'(want.slot));
                    if (o_m_axis_tdata[53:14] !== want.distance)
                        report_mismatch("winner_distance", 64'(o_m_axis_tdata[53:14]),
                                        64'(want.distance));
                    if (o_m_axis_tuser[0] !== want.nores)
                        report_mismatch("no_references", 64'(o_m_axis_tuser[0]),
                                        64'(want.nores));
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                classify_beat(beat_on_bus);
                taken_mark = !taken_mark;
            end
        end
    end

    task automatic queue_beat(input logic [1:0] cmd, input int slot, input int idx,
                              input logic signed [ncc_pkg::ELEMENT_BITS-1:0] value,
                              input logic [ncc_pkg::LABEL_BITS-1:0] label, input bit last);
        t_cmd_beat b;
        b = '{cmd: cmd, slot: ncc_pkg::SLOT_BITS'(slot), idx: ncc_pkg::IDX_BITS'(idx),
              value: value, label: label, last: last};
        if (cmd == ncc_pkg::CMD_REF_WRITE)
            ref_known[b.slot][b.idx] = 1'b1;
        if (cmd == ncc_pkg::CMD_LABEL_WRITE)
            label_known[b.slot] = 1'b1;
        if (counting && cmd != CMD_RESERVED)
            random_beats++;
        command_beats.push_back(b);
    endtask

    // extremes, small values for ties, otherwise anything
    function automatic logic signed [ncc_pkg::ELEMENT_BITS-1:0] rand_element();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3:    return ncc_pkg::ELEMENT_BITS'(int'($urandom_range(4)) - 2);
            default: return ncc_pkg::ELEMENT_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [ncc_pkg::LABEL_BITS-1:0] rand_label();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hff : 8'h00;
        return ncc_pkg::LABEL_BITS'($urandom);
    endfunction

    // waits for the input queue and every expected winner to drain, then lets the block settle
    task automatic wait_idle();
        while (command_beats.size() != 0 || i_s_axis_tvalid || pending_winners.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ncc_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [ncc_pkg::CFG_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ncc_pkg::CFG_VECTOR_LENGTH)
            cfg_len = data;
        else
            cfg_count = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int len, input int cnt);
        wait_idle();
        write_reg(ncc_pkg::CFG_VECTOR_LENGTH, ncc_pkg::CFG_BITS'(len));
        write_reg(ncc_pkg::CFG_REFERENCE_COUNT, ncc_pkg::CFG_BITS'(cnt));
    endtask

    // every element and label that the current setting can read gets written first
    task automatic fill_references();
        int unsigned len_use;
        int unsigned cnt_use;
        len_use = (cfg_len > ncc_pkg::MAX_LENGTH) ? ncc_pkg::MAX_LENGTH : cfg_len;
        cnt_use = (cfg_count > ncc_pkg::MAX_REFS) ? ncc_pkg::MAX_REFS : cfg_count;
        for (int r = 0; r < cnt_use; r++) begin
            for (int i = 0; i < len_use; i++)
                if (!ref_known[r][i])
                    queue_beat(ncc_pkg::CMD_REF_WRITE, r, i, rand_element(), rand_label(),
                               1'($urandom_range(1)));
            if (!label_known[r])
                queue_beat(ncc_pkg::CMD_LABEL_WRITE, r, $urandom_range(63), rand_element(),
                           rand_label(), 1'($urandom_range(1)));
        end
    endtask

    // a write anywhere, a label, or a beat the block drops
    task automatic queue_stray();
        case ($urandom_range(2))
            0: queue_beat(ncc_pkg::CMD_REF_WRITE, $urandom_range(63), $urandom_range(63),
                          rand_element(), rand_label(), 1'($urandom_range(1)));
            1: queue_beat(ncc_pkg::CMD_LABEL_WRITE, $urandom_range(63), $urandom_range(63),
                          rand_element(), rand_label(), 1'($urandom_range(1)));
            default: queue_beat(CMD_RESERVED, $urandom_range(63), $urandom_range(63),
                                rand_element(), rand_label(), 1'($urandom_range(1)));
        endcase
    endtask

    task automatic send_sample();
        int unsigned len_use;
        int unsigned n;
        len_use = (cfg_len > ncc_pkg::MAX_LENGTH) ? ncc_pkg::MAX_LENGTH : cfg_len;
        if ($urandom_range(3) != 0) begin
            // well formed: elements in order, end mark on the last
            n = (len_use == 0) ? 1 : len_use;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(11) == 0)
                    queue_stray();
                queue_beat(ncc_pkg::CMD_SAMPLE, $urandom_range(63),
                           (len_use == 0) ? $urandom_range(63) : i,
                           rand_element(), rand_label(), i == n - 1);
            end
        end else begin
            // broken: any positions, repeats, early end marks, mixed commands
            n = $urandom_range(len_use + 3, 1);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(4) == 0)
                    queue_stray();
                else
                    queue_beat(ncc_pkg::CMD_SAMPLE, $urandom_range(63), $urandom_range(63),
                               rand_element(), rand_label(),
                               (i == n - 1) || ($urandom_range(15) == 0));
            end
        end
    endtask

    // every sum runs into the ceiling and the tie goes to slot 0
    task automatic saturate_run();
        set_config(1, 2);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 0, 0, 16'sh8000, '0, 1'b0);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 1, 0, 16'sh8000, '0, 1'b0);
        queue_beat(ncc_pkg::CMD_LABEL_WRITE, 0, 0, '0, 8'h3c, 1'b0);
        queue_beat(ncc_pkg::CMD_LABEL_WRITE, 1, 0, '0, 8'hc3, 1'b0);
        for (int i = 0; i < 270; i++)
            queue_beat(ncc_pkg::CMD_SAMPLE, 0, 0, 16'sh7fff, '0, i == 269);
    endtask

    initial begin : run_stimulus
        int len;
        int cnt;
        int phase;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: length 1 and no references
        queue_beat(ncc_pkg::CMD_SAMPLE, 0, 0, 16'sh7fff, '0, 1'b1);

        set_config(2, 3);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 0, 0, 16'sh8000, '0, 1'b1);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 0, 1, 16'sh7fff, '0, 1'b0);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 1, 0, 16'sh8000, '0, 1'b0);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 1, 1, 16'sh7fff, '0, 1'b0);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 2, 0, '0, 8'hff, 1'b0);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 2, 1, '0, '0, 1'b0);
        queue_beat(ncc_pkg::CMD_LABEL_WRITE, 0, 0, '0, 8'hff, 1'b1);
        queue_beat(ncc_pkg::CMD_LABEL_WRITE, 1, 0, '0, 8'h5a, 1'b0);
        queue_beat(ncc_pkg::CMD_LABEL_WRITE, 2, 0, '0, 8'h00, 1'b0);
        // far from the two equal references, nearest to the zero one
        queue_beat(ncc_pkg::CMD_SAMPLE, 0, 0, 16'sh7fff, '0, 1'b0);
        queue_beat(ncc_pkg::CMD_SAMPLE, 0, 1, 16'sh8000, '0, 1'b1);
        // exact match with both equal references: lowest slot wins
        queue_beat(ncc_pkg::CMD_SAMPLE, 63, 0, 16'sh8000, 8'hff, 1'b0);
        queue_beat(ncc_pkg::CMD_SAMPLE, 63, 1, 16'sh7fff, 8'hff, 1'b1);
        // an element past the length still ends the sample
        queue_beat(ncc_pkg::CMD_SAMPLE, 0, 63, 16'sh1234, '0, 1'b1);
        queue_beat(CMD_RESERVED, 63, 63, 16'shffff, 8'hff, 1'b1);
        queue_beat(ncc_pkg::CMD_REF_WRITE, 63, 63, 16'shffff, 8'hff, 1'b1);
        queue_beat(ncc_pkg::CMD_LABEL_WRITE, 63, 63, 16'shffff, 8'hff, 1'b1);
        queue_beat(ncc_pkg::CMD_SAMPLE, 0, 0, 16'sh0001, '0, 1'b0);
        queue_beat(ncc_pkg::CMD_SAMPLE, 0, 0, 16'sh0001, '0, 1'b1);

        counting = 1'b1;
        phase    = 0;
        while (random_beats < RANDOM_BEATS) begin
            // the first phases pin the extremes of both registers
            case (phase)
                0:       begin len = 64;  cnt = 2;   end
                1:       begin len = 2;   cnt = 64;  end
                2:       begin len = 127; cnt = 1;   end
                3:       begin len = 1;   cnt = 127; end
                4:       begin len = 0;   cnt = 5;   end
                default: begin
                    case ($urandom_range(9))
                        0:       begin
                                     len = $urandom_range(3) == 0 ? 0 : 64;
                                     cnt = $urandom_range(4);
                                 end
                        1:       begin len = $urandom_range(3, 1); cnt = 64;  end
                        default: begin len = $urandom_range(8, 1); cnt = $urandom_range(8); end
                    endcase
                end
            endcase
            if (phase == 5)
                saturate_run();
            // a long stretch with neither side idling
            no_gaps = (phase >= 8 && phase < 12);
            set_config(len, cnt);
            fill_references();
            repeat ($urandom_range(no_gaps ? 12 : 6, 2)) begin
                send_sample();
                // now and then the sender holds off until every winner is back
                if ($urandom_range(9) == 0)
                    wait_idle();
            end
            phase++;
        end
        no_gaps = 1'b0;

        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/ncc_pkg.sv
rtl/ncc_store.sv
rtl/ncc_dist.sv
rtl/ncc_seq.sv
rtl/nearest_centroid_classifier.sv
tb/tb_nearest_centroid_classifier.sv
